// ===== hw/rtl/rbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcm_pkg: shared types and constants of the ROM block cache miss mapper
// Sizes, code values and handshake structs used by the mapper and its walker.
// ----------------------------------------------------------------------------
package rbcm_pkg;

    localparam int BLOCK_BYTES = 16384;
    localparam int CACHE_SLOTS = 256;
    localparam int ROM_BLOCKS  = 2048;
    localparam int LINK_WORDS  = 512;

    localparam int ADDR_W    = 25;
    localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
    localparam int BLK_W     = $clog2(ROM_BLOCKS);
    localparam int SLOT_W    = $clog2(CACHE_SLOTS);
    localparam int LINK_AW   = $clog2(LINK_WORDS);
    localparam int SECT_SHIFT = 9;
    localparam int CL_W      = ADDR_W - SECT_SHIFT;
    localparam int CSH_W     = 3;
    localparam int FSIZE_W   = 26;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] LCG_SEED = 32'hA512ED48;
    localparam logic [31:0] LCG_MUL  = 32'd1566083941;
    localparam logic [31:0] LCG_INC  = 32'd2531011;
    localparam int DIRECT_BLOCKS     = (2 * 1024 * 1024) / BLOCK_BYTES;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_MISS   = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_NOP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_DIRECT = 2'd1,
        RES_SLOT   = 2'd2
    } t_res;

    typedef enum logic [1:0] {
        CFG_CLUSTER_SHIFT = 2'd0,
        CFG_DATA_BASE     = 2'd1,
        CFG_FILE_SIZE     = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_ADD, S_OWNRD, S_EVICT, S_MAP, S_WALK,
        S_LOOKRD, S_LOOK, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        W_IDLE, W_RDC, W_CHK, W_RDS, W_ADD1, W_ADD2, W_FIN
    } t_wstate;

    typedef struct packed {
        logic        done;
        logic        error;
        logic [31:0] sector;
    } t_walk_rsp;

endpackage

// ===== hw/rtl/rbcm_walker.sv =====
// ----------------------------------------------------------------------------
// rbcm_walker: cluster link map store and fragment walker
// Holds the link map and walks its (count, start) pairs with one shared adder.
// ----------------------------------------------------------------------------
module rbcm_walker
    import rbcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [LINK_AW-1:0] i_wr_idx,
    input  logic [31:0]        i_wr_data,
    input  logic               i_start,
    input  logic [BLK_W-1:0]   i_blk,
    input  logic [CSH_W-1:0]   i_cluster_shift,
    input  logic [31:0]        i_base,
    output t_walk_rsp          o_rsp
);

    logic [31:0] link_mem [LINK_WORDS];
    logic [31:0] r_rd;
    logic [LINK_AW-1:0] rd_addr;

    t_wstate r_state, n_state;
    logic [LINK_AW:0] r_idx;
    logic [CL_W-1:0]  r_cl;
    logic [6:0]       r_csect;
    logic [31:0]      r_acc;
    logic             r_done;
    logic             r_error;
    logic [31:0]      r_sector;

    logic [31:0] add_a, add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic [LINK_AW:0] idx_next;
    logic [CL_W-1:0]  cl_start;
    logic [CL_W-1:0]  sect_pos;
    logic [6:0]       cs_mask;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            link_mem[i_wr_idx] <= i_wr_data;
        end
        r_rd <= link_mem[rd_addr];
    end

    assign sect_pos = CL_W'((ADDR_W'(i_blk) << BLK_SHIFT) >> SECT_SHIFT);
    assign cl_start = sect_pos >> i_cluster_shift;
    assign cs_mask  = (7'd1 << i_cluster_shift) - 7'd1;
    assign idx_next = r_idx + (LINK_AW+1)'(2);

    always_comb begin
        add_a   = 32'(r_cl);
        add_b   = ~r_rd;
        add_cin = 1'b1;
        unique case (r_state)
            W_ADD1: begin
                add_a   = r_rd;
                add_b   = 32'(r_cl);
                add_cin = 1'b0;
            end
            W_ADD2: begin
                add_a   = r_acc;
                add_b   = ~32'd2;
                add_cin = 1'b1;
            end
            W_FIN: begin
                add_a   = i_base;
                add_b   = (r_acc << i_cluster_shift) | 32'(r_csect);
                add_cin = 1'b0;
            end
            default: begin
            end
        endcase
        add_sum = {1'b0, add_a} + {1'b0, add_b} + 33'(add_cin);
    end

    always_comb begin
        n_state = r_state;
        rd_addr = r_idx[LINK_AW-1:0];
        unique case (r_state)
            W_IDLE: if (i_start) n_state = W_RDC;
            W_RDC:  n_state = W_CHK;
            W_CHK: begin
                if (r_rd == 32'd0) begin
                    n_state = W_IDLE;
                end else if (!add_sum[32]) begin
                    n_state = W_RDS;
                end else if (idx_next >= (LINK_AW+1)'(LINK_WORDS - 1)) begin
                    n_state = W_IDLE;
                end else begin
                    n_state = W_RDC;
                end
            end
            W_RDS: begin
                rd_addr = LINK_AW'(r_idx + (LINK_AW+1)'(1));
                n_state = W_ADD1;
            end
            W_ADD1: n_state = W_ADD2;
            W_ADD2: n_state = W_FIN;
            W_FIN:  n_state = W_IDLE;
            default: n_state = W_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            if (r_state == W_CHK && n_state == W_IDLE) begin
                r_done <= 1'b1;
            end
            if (r_state == W_FIN) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            W_IDLE: begin
                r_idx   <= (LINK_AW+1)'(1);
                r_cl    <= cl_start;
                r_csect <= sect_pos[6:0] & cs_mask;
            end
            W_CHK: begin
                if (add_sum[32]) begin
                    r_cl  <= add_sum[CL_W-1:0];
                    r_idx <= idx_next;
                end
                r_error  <= 1'b1;
                r_sector <= 32'd0;
            end
            W_ADD1, W_ADD2: r_acc <= add_sum[31:0];
            W_FIN: begin
                r_error  <= 1'b0;
                r_sector <= add_sum[31:0];
            end
            default: begin
            end
        endcase
    end

    assign o_rsp = {r_done, r_error, r_sector};

endmodule

// ===== hw/rtl/rom_block_cache_miss_mapper.sv =====
// ----------------------------------------------------------------------------
// rom_block_cache_miss_mapper: ROM block cache miss and lookup mapper
// Random-replacement slot choice, slot and residence maps, link map walk.
// ----------------------------------------------------------------------------
// Items arrive on the input channel (i_in_valid / o_in_ready) and each gives
// exactly one result transfer on the output channel (o_out_valid /
// i_out_ready). Registers are written on the configuration channel, which is
// always ready. When a read is needed, a miss walks the link pairs over the
// link map memory with its shared adder. The block takes one item at a time.
// After reset a clearing pass writes all 2048 entries of the residence
// memory, one entry per cycle, and o_in_ready stays low during it. A
// finished result waits in the output register while the receiver stalls;
// the next item may be accepted and worked on, but its result waits until
// the register frees.
// ----------------------------------------------------------------------------
module rom_block_cache_miss_mapper
    import rbcm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_kind,
    input  logic [ADDR_W-1:0]    i_rom_address,
    input  logic [LINK_AW-1:0]   i_table_index,
    input  logic [31:0]          i_table_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [SLOT_W-1:0]    o_victim_index,
    output logic                 o_evicted_valid,
    output logic [BLK_W-1:0]     o_evicted_block,
    output logic [31:0]          o_sd_sector,
    output logic                 o_read_needed,
    output logic                 o_link_error,
    output logic [1:0]           o_lookup_state,
    output logic [SLOT_W-1:0]    o_lookup_index
);

    logic [CSH_W-1:0]   r_cluster_shift;
    logic [31:0]        r_data_base;
    logic [FSIZE_W-1:0] r_file_size;

    t_state r_state, n_state;
    logic [BLK_W-1:0] r_clr_cnt;
    logic [31:0] r_rand, r_prod;
    logic [BLK_W-1:0]  r_blk;

    logic [BLK_W-1:0]   own_mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_own_vld;
    logic [BLK_W-1:0]   r_own_rd;
    logic [SLOT_W+1:0]  res_mem [ROM_BLOCKS];
    logic [SLOT_W+1:0]  r_res_rd;

    logic               res_we;
    logic [BLK_W-1:0]   res_waddr;
    logic [SLOT_W+1:0]  res_wdata;
    logic               own_we;

    logic [SLOT_W-1:0] r_victim;
    logic              r_ev_valid;
    logic [BLK_W-1:0]  r_ev_block;
    logic [31:0]       r_sector;
    logic              r_read_needed;
    logic              r_link_error;
    logic [1:0]        r_lookup_state;
    logic [SLOT_W-1:0] r_lookup_index;

    logic in_fire, out_free, read_needed, walk_start;
    logic [ADDR_W-1:0] blk_ofs;
    t_walk_rsp walk_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !o_out_valid || i_out_ready;
    assign blk_ofs     = ADDR_W'(r_blk) << BLK_SHIFT;
    assign read_needed = FSIZE_W'(blk_ofs) < r_file_size;
    assign walk_start  = (r_state == S_MAP) && read_needed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_shift <= '0;
            r_data_base     <= '0;
            r_file_size     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CLUSTER_SHIFT: r_cluster_shift <= i_cfg_data[CSH_W-1:0];
                CFG_DATA_BASE:     r_data_base     <= i_cfg_data;
                CFG_FILE_SIZE:     r_file_size     <= i_cfg_data[FSIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state   = r_state;
        res_we    = 1'b0;
        res_waddr = r_blk;
        res_wdata = {RES_SLOT, r_victim};
        own_we    = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                res_we    = 1'b1;
                res_waddr = r_clr_cnt;
                res_wdata = (32'(r_clr_cnt) < DIRECT_BLOCKS) ? {RES_DIRECT, SLOT_W'(0)}
                                                             : {RES_NONE, SLOT_W'(0)};
                if (r_clr_cnt == BLK_W'(ROM_BLOCKS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_fire) begin
                    unique case (t_kind'(i_kind))
                        KIND_MISS:   n_state = S_MUL;
                        KIND_LOOKUP: n_state = S_LOOKRD;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_OWNRD;
            S_OWNRD: n_state = S_EVICT;
            S_EVICT: begin
                if (r_own_vld[r_victim]) begin
                    res_we    = 1'b1;
                    res_waddr = r_own_rd;
                    res_wdata = {RES_NONE, SLOT_W'(0)};
                end
                n_state = S_MAP;
            end
            S_MAP: begin
                res_we  = 1'b1;
                own_we  = 1'b1;
                n_state = read_needed ? S_WALK : S_OUT;
            end
            S_WALK:   if (walk_rsp.done) n_state = S_OUT;
            S_LOOKRD: n_state = S_LOOK;
            S_LOOK:   n_state = S_OUT;
            S_OUT:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_rand      <= LCG_SEED;
            r_own_vld   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_cnt <= r_clr_cnt + BLK_W'(1);
            if (r_state == S_ADD) r_rand <= r_prod + LCG_INC;
            if (own_we) r_own_vld[r_victim] <= 1'b1;
            if (r_state == S_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_we) res_mem[res_waddr] <= res_wdata;
        r_res_rd <= res_mem[r_blk];
        if (own_we) own_mem[r_victim] <= r_blk;
        r_own_rd <= own_mem[r_rand[31 -: SLOT_W]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) r_prod <= 32'(r_rand * LCG_MUL);
        if (in_fire) begin
            r_blk          <= i_rom_address[BLK_SHIFT +: BLK_W];
            r_victim       <= '0;
            r_ev_valid     <= 1'b0;
            r_ev_block     <= '0;
            r_sector       <= '0;
            r_read_needed  <= 1'b0;
            r_link_error   <= 1'b0;
            r_lookup_state <= RES_NONE;
            r_lookup_index <= '0;
        end
        if (r_state == S_OWNRD) r_victim <= r_rand[31 -: SLOT_W];
        if (r_state == S_EVICT && r_own_vld[r_victim]) begin
            r_ev_valid <= 1'b1;
            r_ev_block <= r_own_rd;
        end
        if (r_state == S_MAP) r_read_needed <= read_needed;
        if (r_state == S_WALK && walk_rsp.done) begin
            r_sector     <= walk_rsp.sector;
            r_link_error <= walk_rsp.error;
        end
        if (r_state == S_LOOK) begin
            r_lookup_state <= r_res_rd[SLOT_W +: 2];
            if (t_res'(r_res_rd[SLOT_W +: 2]) == RES_SLOT) begin
                r_lookup_index <= r_res_rd[SLOT_W-1:0];
            end
        end
        if (r_state == S_OUT && out_free) begin
            o_victim_index  <= r_victim;
            o_evicted_valid <= r_ev_valid;
            o_evicted_block <= r_ev_block;
            o_sd_sector     <= r_sector;
            o_read_needed   <= r_read_needed;
            o_link_error    <= r_link_error;
            o_lookup_state  <= r_lookup_state;
            o_lookup_index  <= r_lookup_index;
        end
    end

    rbcm_walker u_walker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr_en         (in_fire && t_kind'(i_kind) == KIND_LOAD),
        .i_wr_idx        (i_table_index),
        .i_wr_data       (i_table_word),
        .i_start         (walk_start),
        .i_blk           (r_blk),
        .i_cluster_shift (r_cluster_shift),
        .i_base          (r_data_base),
        .o_rsp           (walk_rsp)
    );

`ifndef SYNTHESIS
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_block == '0)
        else $error("evicted block set without eviction");
    a_link_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_link_error |-> o_read_needed && o_sd_sector == 32'd0)
        else $error("link error without read or with sector");
    a_lookup_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lookup_state != RES_NONE |-> !o_read_needed && !o_evicted_valid)
        else $error("lookup result mixed with miss fields");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_in_ready)
        else $error("input taken during clearing pass");
`endif

endmodule
